[design/quaternion_to_euler_pose_unit_defines.svh]
// ----------------------------------------------------------------------------
// quaternion_to_euler_pose_unit_defines
// assertion helpers for the quaternion to euler pose unit
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_POSE_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_POSE_UNIT_DEFINES_SVH

// same-cycle implication, needs clk and rst_n in scope
`define QTE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pose unit check failed");

// next-cycle implication, needs clk and rst_n in scope
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pose unit check failed");

`endif

[design/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// shared types, constants and angle table of the quaternion to euler pose unit
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int XW  = 38;  // cordic x/y width
  localparam int ZW  = 29;  // cordic angle width, radians * 2^24
  localparam int SQW = 58;  // square root working width

  localparam logic signed [ZW-1:0] ANG_PI    = 29'sd52707179;
  localparam logic signed [ZW-1:0] ROLL_LIM  = 29'sd25736;
  localparam logic signed [ZW-1:0] PITCH_LIM = 29'sd12868;
  localparam logic signed [49:0]   YAW_LIM   = 50'sd11520;
  localparam logic signed [20:0]   DEG_MUL   = 21'sd938735;
  localparam logic signed [24:0]   OFS_X     = 25'sd360448;
  localparam logic signed [24:0]   OFS_Y     = 25'sd32768;
  localparam logic signed [24:0]   POS_MAX   = 25'sd8388607;
  localparam logic signed [24:0]   POS_MIN   = -25'sd8388608;

  typedef enum logic [1:0] {
    REG_SIM_MODE   = 2'd0,
    REG_FIELD_SIDE = 2'd1
  } cfg_reg_t;

  // one vector in flight through the rotation chain
  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

  // partial remainder and root of the square root chain
  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] r;
  } sqrt_t;

  // rounded atan(2^-i) in radians * 2^24
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 29'sd13176795;
      1:  a = 29'sd7778716;
      2:  a = 29'sd4110060;
      3:  a = 29'sd2086331;
      4:  a = 29'sd1047214;
      5:  a = 29'sd524117;
      6:  a = 29'sd262123;
      7:  a = 29'sd131069;
      8:  a = 29'sd65536;
      9:  a = 29'sd32768;
      10: a = 29'sd16384;
      11: a = 29'sd8192;
      12: a = 29'sd4096;
      13: a = 29'sd2048;
      14: a = 29'sd1024;
      15: a = 29'sd512;
      16: a = 29'sd256;
      17: a = 29'sd128;
      18: a = 29'sd64;
      19: a = 29'sd32;
      20: a = 29'sd16;
      21: a = 29'sd8;
      22: a = 29'sd4;
      23: a = 29'sd2;
      24: a = 29'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // zero test and half-turn pre-rotation into the right half plane
  function automatic cvec_t pre_rot(input logic signed [XW-1:0] y,
                                    input logic signed [XW-1:0] x);
    cvec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.z = (y >= 0) ? ANG_PI : -ANG_PI;
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

endpackage

[design/quaternion_to_euler_pose_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_pose_unit
// odometry pose to roll, pitch, yaw degrees and field-offset position
// ----------------------------------------------------------------------------
// channel  | ports                          | transfer
// input    | start, busy, in_*              | start high and busy low
// result   | out_valid, out_*               | out_valid high, one cycle
// config   | cfg_valid, cfg_ready, cfg_*    | cfg_valid and cfg_ready high
//
// one pose enters every cycle; busy stays low
// the pipeline holds six product/term stages, 29 square root cells, one
// pre-rotation stage, the rotation cells and two output stages
// reset clears the valid line and loads simulation mode, right side
// results cannot be stalled; each shows for exactly one cycle
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_pose_unit_defines.svh"

module quaternion_to_euler_pose_unit import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [23:0] in_position_x,
  input  logic signed [23:0] in_position_y,
  output logic               out_valid,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [14:0] out_yaw_degrees,
  output logic signed [23:0] out_field_x,
  output logic signed [23:0] out_field_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);

  localparam int NSQ = 29;
  localparam int LAT = CORDIC_STAGES + 38;

  typedef struct packed {
    logic signed [33:0] sr;
    logic signed [33:0] cr;
    logic signed [33:0] sy;
    logic signed [33:0] cy;
    logic signed [33:0] sp;
    logic               hi;
    logic               lo;
    logic signed [23:0] fx;
    logic signed [23:0] fy;
  } side_t;

  typedef struct packed {
    logic               hi;
    logic               lo;
    logic signed [23:0] fx;
    logic signed [23:0] fy;
  } tail_t;

  // configuration registers
  logic sim_mode_r, field_side_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sim_mode_r   <= 1'b1;
      field_side_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIM_MODE:   sim_mode_r   <= cfg_data;
        REG_FIELD_SIDE: field_side_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // valid line
  logic [LAT-1:0] vld_r, vld_nxt;

  assign vld_nxt = {vld_r[LAT-2:0], start && !busy};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  assign out_valid = vld_r[LAT-1];

  // stage 1: capture pose, offset and saturate position
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [23:0] fx_r, fy_r, fx_nxt, fy_nxt;
  logic signed [24:0] px_sum, py_sum;

  always_comb begin
    px_sum = 25'(in_position_x);
    py_sum = 25'(in_position_y);
    if (!sim_mode_r) begin
      px_sum = px_sum + (field_side_r ? -OFS_X : OFS_X);
      py_sum = py_sum + OFS_Y;
    end
    if (px_sum > POS_MAX)      fx_nxt = POS_MAX[23:0];
    else if (px_sum < POS_MIN) fx_nxt = POS_MIN[23:0];
    else                       fx_nxt = px_sum[23:0];
    if (py_sum > POS_MAX)      fy_nxt = POS_MAX[23:0];
    else if (py_sum < POS_MIN) fy_nxt = POS_MIN[23:0];
    else                       fy_nxt = py_sum[23:0];
  end

  always_ff @(posedge clk) begin
    qw_r <= in_quat_w;
    qx_r <= in_quat_x;
    qy_r <= in_quat_y;
    qz_r <= in_quat_z;
    fx_r <= fx_nxt;
    fy_r <= fy_nxt;
  end

  // stage 2: quaternion products
  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wy_r, p_zx_r;
  logic signed [31:0] p_wz_r, p_xy_r, p_zz_r;
  logic signed [23:0] fx2_r, fy2_r;

  always_ff @(posedge clk) begin
    p_wx_r <= qw_r * qx_r;
    p_yz_r <= qy_r * qz_r;
    p_xx_r <= qx_r * qx_r;
    p_yy_r <= qy_r * qy_r;
    p_wy_r <= qw_r * qy_r;
    p_zx_r <= qz_r * qx_r;
    p_wz_r <= qw_r * qz_r;
    p_xy_r <= qx_r * qy_r;
    p_zz_r <= qz_r * qz_r;
    fx2_r  <= fx_r;
    fy2_r  <= fy_r;
  end

  // stage 3: euler terms in q6.28
  localparam logic signed [33:0] Q28_ONE = 34'sd268435456;
  side_t s3_nxt, s3_r, s4_nxt, s4_r, s5_r, s6_r;

  always_comb begin
    s3_nxt.sr = (34'(p_wx_r) + 34'(p_yz_r)) <<< 1;
    s3_nxt.cr = Q28_ONE - ((34'(p_xx_r) + 34'(p_yy_r)) <<< 1);
    s3_nxt.sp = (34'(p_wy_r) - 34'(p_zx_r)) <<< 1;
    s3_nxt.sy = (34'(p_wz_r) + 34'(p_xy_r)) <<< 1;
    s3_nxt.cy = Q28_ONE - ((34'(p_yy_r) + 34'(p_zz_r)) <<< 1);
    s3_nxt.hi = 1'b0;
    s3_nxt.lo = 1'b0;
    s3_nxt.fx = fx2_r;
    s3_nxt.fy = fy2_r;
  end

  // stage 4: pitch domain test and magnitude
  logic [27:0]        sp_abs_r;
  logic signed [33:0] sp_neg;

  always_comb begin
    s4_nxt    = s3_r;
    s4_nxt.hi = s3_r.sp >= Q28_ONE;
    s4_nxt.lo = s3_r.sp <= -Q28_ONE;
    sp_neg    = -s3_r.sp;
  end

  // stage 5: square, stage 6: remainder 1 - sp^2
  logic [55:0]    sp_sq_r;
  logic [SQW-1:0] rem_r;

  always_ff @(posedge clk) begin
    s3_r     <= s3_nxt;
    s4_r     <= s4_nxt;
    sp_abs_r <= (s3_r.sp < 0) ? sp_neg[27:0] : s3_r.sp[27:0];
    s5_r     <= s4_r;
    sp_sq_r  <= sp_abs_r * sp_abs_r;
    s6_r     <= s5_r;
    rem_r    <= (SQW'(1) << 56) - SQW'(sp_sq_r);
  end

  // square root chain, one root bit per cell
  sqrt_t sq_w [0:NSQ];
  side_t sq_side_r [0:NSQ-1];

  assign sq_w[0].v = rem_r;
  assign sq_w[0].r = '0;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    qte_sqrt_cell #(.K(NSQ - 1 - j)) u_cell (
      .clk  (clk),
      .in_s (sq_w[j]),
      .out_s(sq_w[j+1])
    );
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        sq_side_r[j] <= s6_r;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        sq_side_r[j] <= sq_side_r[j-1];
      end
    end
  end

  // pre-rotation stage for roll, pitch, yaw lanes
  side_t                sd;
  logic signed [XW-1:0] pc;
  cvec_t                pre_r [0:2];
  cvec_t                cv_w [0:CORDIC_STAGES][0:2];
  tail_t                tail_r [0:CORDIC_STAGES];

  assign sd = sq_side_r[NSQ-1];
  assign pc = XW'(sq_w[NSQ].r[28:0]);

  always_ff @(posedge clk) begin
    pre_r[0]     <= pre_rot(XW'(sd.sr), XW'(sd.cr));
    pre_r[1]     <= pre_rot(XW'(sd.sp), pc);
    pre_r[2]     <= pre_rot(XW'(sd.sy), XW'(sd.cy));
    tail_r[0].hi <= sd.hi;
    tail_r[0].lo <= sd.lo;
    tail_r[0].fx <= sd.fx;
    tail_r[0].fy <= sd.fy;
  end

  assign cv_w[0][0] = pre_r[0];
  assign cv_w[0][1] = pre_r[1];
  assign cv_w[0][2] = pre_r[2];

  // rotation chain, three lanes side by side
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    for (genvar l = 0; l < 3; l++) begin : g_lane
      qte_cordic_cell #(.I(i)) u_cell (
        .clk  (clk),
        .in_v (cv_w[i][l]),
        .out_v(cv_w[i+1][l])
      );
    end
    always_ff @(posedge clk) begin
      tail_r[i+1] <= tail_r[i];
    end
  end

  // post stage 1: q2.13 rounding, clamps, degree product
  cvec_t                rv, pv, yv;
  tail_t                tl;
  logic signed [ZW-1:0] rz, pz, yz, rq, pq;
  logic signed [15:0]   roll_nxt, roll_r;
  logic signed [14:0]   pitch_nxt, pitch_r;
  logic signed [49:0]   yprod_r;
  logic signed [23:0]   fx_p_r, fy_p_r;

  assign rv = cv_w[CORDIC_STAGES][0];
  assign pv = cv_w[CORDIC_STAGES][1];
  assign yv = cv_w[CORDIC_STAGES][2];
  assign tl = tail_r[CORDIC_STAGES];

  always_comb begin
    rz = rv.zero ? '0 : rv.z;
    pz = pv.zero ? '0 : pv.z;
    yz = yv.zero ? '0 : yv.z;
    rq = (rz + ZW'(1024)) >>> 11;
    pq = (pz + ZW'(1024)) >>> 11;
    if (rq > ROLL_LIM)       roll_nxt = ROLL_LIM[15:0];
    else if (rq < -ROLL_LIM) roll_nxt = 16'(-ROLL_LIM);
    else                     roll_nxt = rq[15:0];
    if (tl.hi)                pitch_nxt = PITCH_LIM[14:0];
    else if (tl.lo)           pitch_nxt = 15'(-PITCH_LIM);
    else if (pq > PITCH_LIM)  pitch_nxt = PITCH_LIM[14:0];
    else if (pq < -PITCH_LIM) pitch_nxt = 15'(-PITCH_LIM);
    else                      pitch_nxt = pq[14:0];
  end

  always_ff @(posedge clk) begin
    roll_r  <= roll_nxt;
    pitch_r <= pitch_nxt;
    yprod_r <= 50'(yz) * 50'(DEG_MUL);
    fx_p_r  <= tl.fx;
    fy_p_r  <= tl.fy;
  end

  // post stage 2: degree rounding and output registers
  logic signed [49:0] deg_full;
  logic signed [14:0] deg_nxt;

  always_comb begin
    deg_full = (yprod_r + (50'sd1 <<< 31)) >>> 32;
    if (deg_full > YAW_LIM)       deg_nxt = YAW_LIM[14:0];
    else if (deg_full < -YAW_LIM) deg_nxt = 15'(-YAW_LIM);
    else                          deg_nxt = deg_full[14:0];
  end

  always_ff @(posedge clk) begin
    out_roll_angle  <= roll_r;
    out_pitch_angle <= pitch_r;
    out_yaw_degrees <= deg_nxt;
    out_field_x     <= fx_p_r;
    out_field_y     <= fy_p_r;
  end

  // checks
  `QTE_ASSERT_NEXT(a_accept_enters, start && !busy, vld_r[0])
  `QTE_ASSERT_SAME(a_roll_rng, out_valid, out_roll_angle <= 16'sd25736 && out_roll_angle >= -16'sd25736)
  `QTE_ASSERT_SAME(a_pitch_rng, out_valid, out_pitch_angle <= 15'sd12868 && out_pitch_angle >= -15'sd12868)
  `QTE_ASSERT_SAME(a_yaw_rng, out_valid, out_yaw_degrees <= 15'sd11520 && out_yaw_degrees >= -15'sd11520)

endmodule

[design/qte_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// one registered step of the bit-pair integer square root
// ----------------------------------------------------------------------------
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int K = 0
) (
  input  logic  clk,
  input  sqrt_t in_s,
  output sqrt_t out_s
);

  localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

  sqrt_t          s_nxt;
  sqrt_t          s_r;
  logic [SQW-1:0] trial;

  // try to take the next root bit
  always_comb begin
    trial = in_s.r + BIT;
    if (in_s.v >= trial) begin
      s_nxt.v = in_s.v - trial;
      s_nxt.r = (in_s.r >> 1) + BIT;
    end else begin
      s_nxt.v = in_s.v;
      s_nxt.r = in_s.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  assign out_s = s_r;

endmodule

[design/qte_cordic_cell.sv]
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one registered vectoring rotation of the atan2 chain
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; #(
  parameter int I = 0
) (
  input  logic  clk,
  input  cvec_t in_v,
  output cvec_t out_v
);

  localparam logic signed [ZW-1:0] ANG = atan_val(I);

  cvec_t                v_nxt;
  cvec_t                v_r;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  // rotate toward the x axis
  always_comb begin
    xs         = in_v.x >>> I;
    ys         = in_v.y >>> I;
    v_nxt.zero = in_v.zero;
    if (in_v.y >= 0) begin
      v_nxt.x = in_v.x + ys;
      v_nxt.y = in_v.y - xs;
      v_nxt.z = in_v.z + ANG;
    end else begin
      v_nxt.x = in_v.x - ys;
      v_nxt.y = in_v.y + xs;
      v_nxt.z = in_v.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign out_v = v_r;

endmodule
